// ===== src/hsdr_pkg.sv =====
// Shared types, command codes and coil tables for the stepper and drop meter.
`timescale 1ns / 1ps

package hsdr_pkg;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   localparam logic signed [15:0] STEP_MAX = 16'sh7FFF;
   localparam logic signed [15:0] STEP_MIN = 16'sh8000;

   localparam logic [3:0] FWD_COILS [8] = '{
      4'b1000, 4'b1100, 4'b0100, 4'b0110, 4'b0010, 4'b0011, 4'b0001, 4'b1001
   };
   localparam logic [3:0] REV_COILS [8] = '{
      4'b0001, 4'b0011, 4'b0010, 4'b0110, 4'b0100, 4'b1100, 4'b1000, 4'b1001
   };

   typedef struct packed {
      logic               command;
      logic               drop_first;
      logic               drop_second;
      logic signed [15:0] move_steps;
   } req_type;

   typedef struct packed {
      logic [3:0] coil_drive;
      logic [7:0] drops_seen;
      logic [7:0] gap_average;
      logic       moving;
      logic       move_finished;
   } rsp_type;

   typedef struct packed {
      logic [3:0] coil_drive;
      logic       moving;
      logic       move_finished;
   } step_status_type;

   typedef struct packed {
      logic [7:0] drops_seen;
      logic [7:0] gap_average;
   } meter_status_type;

endpackage

// ===== src/hsdr_drop_meter.sv =====
// Tick timer, falling-edge drop counter, stamp ring and gap average.
`timescale 1ns / 1ps

module hsdr_drop_meter #(
   parameter int RING_DEPTH = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      tick,
   input  logic [1:0]                samples,
   output hsdr_pkg::meter_status_type status
);

   localparam int SLOT_W = $clog2(RING_DEPTH);
   localparam int DIV = RING_DEPTH - 1;
   localparam int SHIFT = 16;
   localparam logic [16:0] RECIP = 17'(((1 << SHIFT) + DIV - 1) / DIV);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);

   logic [7:0]        tick_time_ff, tick_time_in;
   logic              last_level_ff, last_level_in;
   logic [7:0]        drop_total_ff, drop_total_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [7:0]        ring_ff [RING_DEPTH];
   logic [7:0]        ring_in [RING_DEPTH];
   logic [7:0]        gap_ff, gap_in;
   logic [7:0]        diff;
   logic [24:0]       product;

   always_comb begin
      tick_time_in  = tick_time_ff + 8'd1;
      last_level_in = last_level_ff;
      drop_total_in = drop_total_ff;
      slot_in       = slot_ff;
      ring_in       = ring_ff;
      gap_in        = gap_ff;
      diff          = '0;
      product       = '0;
      for (int k = 0; k < 2; k++) begin
         if (last_level_in && !samples[k]) begin
            drop_total_in = drop_total_in + 8'd1;
            if (drop_total_in == 8'd0 || slot_in == LAST_SLOT) begin
               slot_in = '0;
            end else begin
               slot_in = slot_in + SLOT_W'(1);
            end
            ring_in[slot_in] = tick_time_in;
            if (slot_in == LAST_SLOT) begin
               diff    = tick_time_in - ring_in[0];
               product = {17'd0, diff} * {8'd0, RECIP};
               gap_in  = product[SHIFT+7:SHIFT];
            end
         end
         last_level_in = samples[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_time_ff  <= '0;
         last_level_ff <= 1'b0;
         drop_total_ff <= '0;
         slot_ff       <= '0;
         gap_ff        <= '0;
         for (int i = 0; i < RING_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
      end else if (tick) begin
         tick_time_ff  <= tick_time_in;
         last_level_ff <= last_level_in;
         drop_total_ff <= drop_total_in;
         slot_ff       <= slot_in;
         gap_ff        <= gap_in;
         ring_ff       <= ring_in;
      end
   end

   always_comb begin
      status.drops_seen  = tick ? drop_total_in : drop_total_ff;
      status.gap_average = tick ? gap_in : gap_ff;
   end

endmodule

// ===== src/hsdr_stepper.sv =====
// Half-step phase sequencer that walks progress toward a signed move target.
`timescale 1ns / 1ps

module hsdr_stepper (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  logic                     tick,
   input  logic signed [15:0]       move_steps,
   output hsdr_pkg::step_status_type status
);

   logic signed [15:0] target_ff, target_in;
   logic signed [15:0] progress_ff, progress_in;
   logic [2:0]         phase_ff, phase_in;
   logic [3:0]         coil_ff, coil_in;
   logic               finished;

   always_comb begin
      target_in   = target_ff;
      progress_in = progress_ff;
      phase_in    = phase_ff;
      coil_in     = coil_ff;
      finished    = 1'b0;
      if (load) begin
         target_in = move_steps;
      end else if (tick) begin
         if (target_ff > 16'sd0) begin
            if (progress_in > target_ff) begin
               target_in   = '0;
               progress_in = '0;
               finished    = 1'b1;
            end
            if (progress_in != hsdr_pkg::STEP_MAX) begin
               progress_in = progress_in + 16'sd1;
            end
            coil_in  = hsdr_pkg::FWD_COILS[phase_ff];
            phase_in = phase_ff + 3'd1;
         end else if (target_ff < 16'sd0) begin
            if (progress_in < target_ff) begin
               target_in   = '0;
               progress_in = '0;
               finished    = 1'b1;
            end
            if (progress_in != hsdr_pkg::STEP_MIN) begin
               progress_in = progress_in - 16'sd1;
            end
            coil_in  = hsdr_pkg::REV_COILS[phase_ff];
            phase_in = phase_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= '0;
         progress_ff <= '0;
         phase_ff    <= '0;
         coil_ff     <= '0;
      end else begin
         target_ff   <= target_in;
         progress_ff <= progress_in;
         phase_ff    <= phase_in;
         coil_ff     <= coil_in;
      end
   end

   always_comb begin
      status.coil_drive    = coil_in;
      status.moving        = (target_in != 16'sd0);
      status.move_finished = finished;
   end

endmodule

// ===== src/half_step_stepper_and_drop_rate_meter.sv =====
// Top level: half-step stepper sequencer with drop counting and gap averaging.
//
//   channel  ports                            carries
//   input    req_valid, req_ready, req_data   command word: tick samples or move target
//   output   rsp_valid, rsp_ready, rsp_data   coil drive, drop count, gap, move status
//
// Each word's state update is computed from the accepted word and lands in
// the state registers and the result register at the same edge, so a new word
// can be taken every cycle while the result side is not stalled.
// The result register is the only stage; input is taken while it is empty or
// being drained, and a stalled result holds until it is taken.
// Reset clears stepper and meter state, the stamp ring and rsp_valid, not rsp_data.
`timescale 1ns / 1ps

module half_step_stepper_and_drop_rate_meter #(
   parameter int RING_DEPTH = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hsdr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hsdr_pkg::rsp_type rsp_data
);

   logic                       accept;
   logic                       tick;
   logic                       load;
   logic                       rsp_valid_ff, rsp_valid_in;
   hsdr_pkg::rsp_type          rsp_data_ff, rsp_data_in;
   hsdr_pkg::step_status_type  step_status;
   hsdr_pkg::meter_status_type meter_status;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign tick      = accept && (req_data.command == hsdr_pkg::CMD_TICK);
   assign load      = accept && (req_data.command == hsdr_pkg::CMD_LOAD);

   hsdr_drop_meter #(
      .RING_DEPTH(RING_DEPTH)
   ) u_meter (
      .clock  (clock),
      .reset  (reset),
      .tick   (tick),
      .samples({req_data.drop_second, req_data.drop_first}),
      .status (meter_status)
   );

   hsdr_stepper u_stepper (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .tick      (tick),
      .move_steps(req_data.move_steps),
      .status    (step_status)
   );

   always_comb begin
      rsp_valid_in              = accept || (rsp_valid_ff && !rsp_ready);
      rsp_data_in.coil_drive    = step_status.coil_drive;
      rsp_data_in.drops_seen    = meter_status.drops_seen;
      rsp_data_in.gap_average   = meter_status.gap_average;
      rsp_data_in.moving        = step_status.moving;
      rsp_data_in.move_finished = step_status.move_finished;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/hsdr_checker.sv =====
// Port-level checks for the stepper and drop meter, bound to the top level.
`timescale 1ns / 1ps

module hsdr_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input hsdr_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input hsdr_pkg::rsp_type rsp_data
);

   // A stalled result must hold its word.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Input is never refused while the result side can take a word.
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("input refused with free result stage");

   // A finished move always reports the stepper idle.
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.move_finished |-> !rsp_data.moving)
      else $error("move finished while still moving");

   // Loading a nonzero target reports moving and no completion next cycle.
   a_load_moves: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.command == hsdr_pkg::CMD_LOAD) &&
      (req_data.move_steps != 16'sd0)
      |=> rsp_valid && rsp_data.moving && !rsp_data.move_finished)
      else $error("load of nonzero target not reported as moving");

endmodule

bind half_step_stepper_and_drop_rate_meter hsdr_checker u_hsdr_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);
